[src/lis_pkg.sv]
package lis_pkg;

  localparam int MAX_LEN      = 1024;
  localparam int SAMPLE_WIDTH = 32;
  localparam int ADDR_W       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W        = 11;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the incoming beat, start the first search read
    logic search;    // advance the binary search by one step
    logic commit;    // apply the table/length update
    logic out_load;  // load the result register
  } lis_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start;     // new sequence (first flag or empty table)
    logic below;     // sample below the first tail
    logic above;     // sample above the last tail
    logic found;     // search range already a single entry
    logic done;      // this search step closes the range
  } lis_status_t;

endpackage

[src/lis_datapath.sv]
module lis_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic signed [lis_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                                   first,
  input  logic                                   last,
  input  lis_pkg::lis_cmd_t                      cmd,
  output lis_pkg::lis_status_t                   status,
  output logic [lis_pkg::LEN_W-1:0]              lis_length,
  output logic                                   overflow,
  output logic                                   final_res
);
  import lis_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] mem [MAX_LEN];
  logic signed [SAMPLE_WIDTH-1:0] rd_data;
  logic signed [SAMPLE_WIDTH-1:0] smp;
  logic signed [SAMPLE_WIDTH-1:0] tail0;
  logic signed [SAMPLE_WIDTH-1:0] tail_last;
  logic                           first_q;
  logic                           last_q;
  logic [LEN_W-1:0]               length;
  logic                           overflow_seen;
  logic [ADDR_W-1:0]              lo;
  logic [ADDR_W-1:0]              hi;

  logic [LEN_W-1:0]  len_m1;
  logic [ADDR_W-1:0] mid;
  logic [ADDR_W-1:0] lo_next;
  logic [ADDR_W-1:0] hi_next;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;
  logic              full;
  logic              ge;

  function automatic logic [ADDR_W-1:0] mid_of(input logic [ADDR_W-1:0] a,
                                               input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_W:1];
  endfunction

  assign len_m1 = length - LEN_W'(1);
  assign full   = (length == LEN_W'(MAX_LEN));
  assign mid    = mid_of(lo, hi);
  assign ge     = (rd_data >= smp);

  always_comb begin
    if (ge) begin
      lo_next = lo;
      hi_next = mid;
    end else begin
      lo_next = mid + ADDR_W'(1);
      hi_next = hi;
    end
  end

  always_comb begin
    if (cmd.capture) begin
      rd_addr = len_m1[ADDR_W:1];
    end else if (cmd.search) begin
      rd_addr = mid_of(lo_next, hi_next);
    end else begin
      rd_addr = mid;
    end
  end

  assign status.start = first_q || (length == '0);
  assign status.below = (smp < tail0);
  assign status.above = (smp > tail_last);
  assign status.found = (lo == hi);
  assign status.done  = (lo_next == hi_next);

  assign pos = cmd.search ? lo_next : lo;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    if (cmd.commit) begin
      if (status.start || status.below) begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end else if (status.above) begin
        wr_en   = !full;
        wr_addr = length[ADDR_W-1:0];
      end else begin
        wr_en   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= smp;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp     <= sample;
      first_q <= first;
      last_q  <= last;
      lo      <= '0;
      hi      <= len_m1[ADDR_W-1:0];
    end else if (cmd.search) begin
      lo <= lo_next;
      hi <= hi_next;
    end
    if (cmd.commit) begin
      if (status.start) begin
        tail0     <= smp;
        tail_last <= smp;
      end else if (status.below) begin
        tail0 <= smp;
        if (length == LEN_W'(1)) begin
          tail_last <= smp;
        end
      end else if (status.above) begin
        if (!full) begin
          tail_last <= smp;
        end
      end else begin
        if (pos == '0) begin
          tail0 <= smp;
        end
        if (pos == len_m1[ADDR_W-1:0]) begin
          tail_last <= smp;
        end
      end
    end
    if (cmd.out_load) begin
      lis_length <= length;
      overflow   <= overflow_seen;
      final_res  <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length        <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.commit) begin
      if (status.start) begin
        length        <= LEN_W'(1);
        overflow_seen <= 1'b0;
      end else if (!status.below && status.above) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          length <= length + LEN_W'(1);
        end
      end
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(MAX_LEN))
    else $error("table length past depth");

  a_len_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(length))
    else $error("length changed outside a commit");

  a_search_range: assert property (@(posedge clk) disable iff (rst)
    cmd.search |-> lo < hi)
    else $error("search step on a closed range");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    $rose(overflow_seen) |-> full)
    else $error("overflow set with room left in table");

endmodule

[src/lis_ctrl.sv]
module lis_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  lis_pkg::lis_status_t status,
  output lis_pkg::lis_cmd_t    cmd
);
  import lis_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   resolved;

  assign resolved = status.start || status.below || status.above || status.found;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (resolved) begin
          cmd.commit = 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (status.done) begin
          cmd.commit = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.search, cmd.out_load}))
    else $error("conflicting datapath commands");

  a_commit_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> state == S_OUT)
    else $error("commit not followed by result load");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !in_ready)
    else $error("second beat taken while busy");

endmodule

[src/longest_increasing_subsequence.sv]
// Streaming longest strictly increasing subsequence length (patience method).
// Each input beat is one signed sample; first starts a new sequence, last is
// echoed as final_res. Every sample yields one result beat with the current
// length and a sticky overflow flag (set once an extension is dropped because
// the 1024-entry tail table is full). One sample is worked on at a time: a
// beat that starts a sequence, falls below the first tail or above the last
// tail is resolved without a search; otherwise a binary search over the
// tails finds the entry to replace, stepping once per cycle through the tail
// memory's single registered read port. The result register frees the input
// side as soon as the result is loaded.
module longest_increasing_subsequence (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [lis_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                                   first,
  input  logic                                   last,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [lis_pkg::LEN_W-1:0]              lis_length,
  output logic                                   overflow,
  output logic                                   final_res
);
  import lis_pkg::*;

  lis_cmd_t    cmd;
  lis_status_t status;

  lis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lis_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .first      (first),
    .last       (last),
    .cmd        (cmd),
    .status     (status),
    .lis_length (lis_length),
    .overflow   (overflow),
    .final_res  (final_res)
  );

endmodule
